// ===== rtl/core/mexp_pkg.sv =====
`default_nettype none

package mexp_pkg;

  localparam int unsigned DATA_W = 30;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned RED_W  = 32;

  localparam logic [DATA_W-1:0] MODULUS   = DATA_W'(1000000007);
  localparam logic [RED_W-1:0]  MODULUS_2 = RED_W'(2 * 1000000007);

  // Barrett constant floor(2^60 / M); fits in 31 bits since M > 2^29
  localparam logic [DATA_W:0] BARRETT_MU =
    (DATA_W + 1)'((64'd1 << PROD_W) / 64'd1000000007);

  localparam int unsigned STEP_W = 3;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_MUL,
    OP_SQR
  } op_t;

  // One microcode word
  typedef struct packed {
    op_t  op;
    logic wb_acc;
    logic wb_sq;
    logic last_step;
  } ctrl_t;

  // Control from sequencer to datapath
  typedef struct packed {
    logic load;
    op_t  op;
    logic wb_acc;
    logic wb_sq;
    logic emit;
  } dp_ctl_t;

  // Program for one exponent bit. The mulmod pipe has four register stages,
  // so an operation's writeback comes in a later step, once its result has left the pipe.
  function automatic ctrl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '{op: OP_NOP, wb_acc: 1'b0, wb_sq: 1'b0, last_step: 1'b0};
    case (step)
      3'd0: w.op = OP_MUL;
      3'd1: w.op = OP_SQR;
      3'd2: w.op = OP_NOP;
      3'd3: w.op = OP_NOP;
      3'd4: w.wb_acc = 1'b1;
      3'd5: begin
        w.wb_sq     = 1'b1;
        w.last_step = 1'b1;
      end
      default: w.last_step = 1'b1;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mexp_if.sv =====
`default_nettype none

interface mexp_in_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] base;
  logic [DATA_W-1:0] exponent;

  modport source(output valid, base, exponent, input ready);
  modport sink(input valid, base, exponent, output ready);
endinterface

interface mexp_out_if import mexp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] power;

  modport source(output valid, power, input ready);
  modport sink(input valid, power, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mexp_mulmod.sv =====
`default_nettype none

module mexp_mulmod import mexp_pkg::*; (
  input  wire logic              clk,
  input  wire logic [DATA_W-1:0] op_a,
  input  wire logic [DATA_W-1:0] op_b,
  output logic      [DATA_W-1:0] res
);

  logic [PROD_W-1:0]     prod;
  logic [2*DATA_W+1:0]   quot_est;
  logic [RED_W-1:0]      p_lo2;
  logic [RED_W-1:0]      p_lo3;
  logic [RED_W-1:0]      qm;
  logic [RED_W-1:0]      rem;
  logic [DATA_W:0]       q1;
  logic [DATA_W:0]       q3;

  assign q1 = prod[PROD_W-1:DATA_W-1];
  assign q3 = quot_est[2*DATA_W+1:DATA_W+1];

  always_ff @(posedge clk) begin
    prod     <= PROD_W'(op_a) * PROD_W'(op_b);
    quot_est <= (2*DATA_W+2)'(q1) * (2*DATA_W+2)'(BARRETT_MU);
    p_lo2    <= prod[RED_W-1:0];
    // only the low word matters: the remainder stays below 3M < 2^32
    qm       <= RED_W'(q3) * RED_W'(MODULUS);
    p_lo3    <= p_lo2;
    rem      <= p_lo3 - qm;
  end

  // Barrett estimate is short by at most two multiples of M
  always_comb begin
    if (rem >= MODULUS_2) begin
      res = DATA_W'(rem - MODULUS_2);
    end else if (rem >= RED_W'(MODULUS)) begin
      res = DATA_W'(rem - RED_W'(MODULUS));
    end else begin
      res = DATA_W'(rem);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mexp_seq.sv =====
`default_nettype none

module mexp_seq import mexp_pkg::*; #(
  parameter int unsigned EXP_BITS = 30
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic out_free,
  output logic      idle,
  output dp_ctl_t   ctl
);

  localparam int unsigned CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  bit_cnt;
  ctrl_t             uword;

  assign uword = ucode_rom(step);
  assign idle  = (state == S_IDLE);

  always_comb begin
    ctl = '{load: 1'b0, op: OP_NOP, wb_acc: 1'b0, wb_sq: 1'b0, emit: 1'b0};
    case (state)
      S_IDLE: ctl.load = start;
      S_RUN: begin
        ctl.op     = uword.op;
        ctl.wb_acc = uword.wb_acc;
        ctl.wb_sq  = uword.wb_sq;
      end
      S_DONE: ctl.emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= '0;
      bit_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          step    <= '0;
          bit_cnt <= '0;
          if (start) state <= S_RUN;
        end
        S_RUN: begin
          if (uword.last_step) begin
            step <= '0;
            if (bit_cnt == CNT_W'(EXP_BITS - 1)) begin
              state <= S_DONE;
            end else begin
              bit_cnt <= bit_cnt + 1'b1;
            end
          end else begin
            step <= step + 1'b1;
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/modular_exponentiation.sv =====
// Modular exponentiation: power = base ^ exponent mod 1000000007.
//
// Channels: item (sink) carries base and exponent, result (source) carries
// power. A transfer happens on a rising edge with valid and ready both high.
// base is expected below the modulus; a base up to 2^30-1 is reduced once.
//
// The block works on one item at a time. ready is high only while idle.
// Each of the EXP_BITS exponent bits runs a six-step microcode program on
// one shared mulmod unit (30x30 product, Barrett reduction, four register
// stages): one multiply, one square, writeback. An item runs through all
// exponent bits and then waits in the done state until the output register
// is free and takes power; only after that does the block return to idle
// and take the next item.
//
// The output register holds the result while the receiver stalls; the block
// takes the next item meanwhile and waits at its end until the register is
// free. Reset empties the output register and returns the sequencer to idle.
`default_nettype none

module modular_exponentiation import mexp_pkg::*; #(
  parameter int unsigned EXP_BITS = 30
) (
  input  wire logic clk,
  input  wire logic rst,
  mexp_in_if.sink   item,
  mexp_out_if.source result
);

  logic              idle;
  logic              out_free;
  logic              out_valid;
  logic [DATA_W-1:0] power;
  logic [DATA_W-1:0] acc;
  logic [DATA_W-1:0] sq;
  logic [DATA_W-1:0] expo;
  logic [DATA_W-1:0] mul_a;
  logic [DATA_W-1:0] mul_res;
  dp_ctl_t           ctl;

  assign item.ready   = idle;
  assign result.valid = out_valid;
  assign result.power = power;
  assign out_free     = !out_valid || result.ready;

  mexp_seq #(
    .EXP_BITS(EXP_BITS)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (item.valid),
    .out_free(out_free),
    .idle    (idle),
    .ctl     (ctl)
  );

  assign mul_a = (ctl.op == OP_SQR) ? sq : acc;

  mexp_mulmod u_mulmod (
    .clk (clk),
    .op_a(mul_a),
    .op_b(sq),
    .res (mul_res)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      acc  <= DATA_W'(1);
      sq   <= (item.base >= MODULUS) ? item.base - MODULUS : item.base;
      expo <= item.exponent;
    end else begin
      if (ctl.wb_acc && expo[0]) acc <= mul_res;
      // advance to the next exponent bit
      if (ctl.wb_sq) begin
        sq   <= mul_res;
        expo <= expo >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) power <= acc;
  end

endmodule

`default_nettype wire

// ===== tb/sv/power_checker.sv =====
`timescale 1ns / 1ps

module power_checker import mexp_pkg::*; (
  input  logic clk,
  input  logic rst,
  mexp_in_if   item,
  mexp_out_if  result,
  output int   fail_count,
  output int   pending,
  output int   result_count
);

  localparam int unsigned EXP_BITS = 30;
  localparam logic [63:0] PRIME = 64'(MODULUS);

  typedef struct {
    logic [DATA_W-1:0] base;
    logic [DATA_W-1:0] exponent;
    logic [DATA_W-1:0] power;
  } power_job_t;

  power_job_t expected_powers[$];
  int fails = 0;
  int seen = 0;

  // Right-to-left square-and-multiply over the low EXP_BITS exponent bits.
  function automatic logic [DATA_W-1:0] mod_power(input logic [DATA_W-1:0] b,
                                                  input logic [DATA_W-1:0] e);
    logic [63:0] sq;
    logic [63:0] acc;
    sq  = 64'(b) % PRIME;
    acc = 64'd1;
    for (int i = 0; i < EXP_BITS; i++) begin
      if (e[i]) acc = (acc * sq) % PRIME;
      sq = (sq * sq) % PRIME;
    end
    return acc[DATA_W-1:0];
  endfunction

  always @(posedge clk) begin
    power_job_t job;
    if (!rst) begin
      // retire first: a result never belongs to the item taken at the same edge
      if (result.valid && result.ready) begin
        seen++;
        if (expected_powers.size() == 0) begin
          fails++;
          $display("%0t: unexpected result: expected none, got power %0d",
                   $time, result.power);
        end else begin
          job = expected_powers.pop_front();
          if (result.power !== job.power) begin
            fails++;
            $display("%0t: power mismatch for base %0d exponent %0d: expected %0d, got %0d",
                     $time, job.base, job.exponent, job.power, result.power);
          end
        end
      end
      if (item.valid && item.ready) begin
        job.base     = item.base;
        job.exponent = item.exponent;
        job.power    = mod_power(item.base, item.exponent);
        expected_powers.push_back(job);
      end
    end
    fail_count   <= fails;
    pending      <= expected_powers.size();
    result_count <= seen;
  end

endmodule

// ===== tb/sv/modular_exponentiation_tb.sv =====
`timescale 1ns / 1ps

module modular_exponentiation_tb;
  import mexp_pkg::*;

  localparam int unsigned PRIME        = 32'(MODULUS);
  localparam int unsigned TOP_30       = 32'h3FFF_FFFF;
  localparam int unsigned RANDOM_ITEMS = 430;
  localparam int unsigned HOLD_CYCLES  = 1200;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mexp_in_if  item_if ();
  mexp_out_if result_if ();

  int fail_count;
  int pending;
  int result_count;

  bit calm = 1'b0;
  bit hold_off_go = 1'b0;
  int unsigned sent = 0;
  int unsigned cycle_count = 0;

  modular_exponentiation DUT (
    .clk(clk),
    .rst(rst),
    .item(item_if),
    .result(result_if)
  );

  power_checker u_checker (
    .clk(clk),
    .rst(rst),
    .item(item_if),
    .result(result_if),
    .fail_count(fail_count),
    .pending(pending),
    .result_count(result_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(60, 250);
  endfunction

  task automatic send_item(input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] e);
    int unsigned gap;
    item_if.valid    <= 1'b1;
    item_if.base     <= b;
    item_if.exponent <= e;
    do @(posedge clk); while (!item_if.ready);
    sent++;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left = 0;
    hold_left  = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        hold_left   = HOLD_CYCLES;
        hold_off_go = 1'b0;
      end
      if (hold_left != 0) begin
        result_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left != 0 && !calm) begin
        result_if.ready <= 1'b0;
        stall_left--;
      end else begin
        result_if.ready <= 1'b1;
        stall_left = 0;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  initial begin
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] e;
    int unsigned n_directed;

    item_if.valid    <= 1'b0;
    item_if.base     <= '0;
    item_if.exponent <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // corners of both fields, zero exponent, unreduced bases
    send_item(DATA_W'(0), DATA_W'(0));
    send_item(DATA_W'(0), DATA_W'(1));
    send_item(DATA_W'(0), DATA_W'(TOP_30));
    send_item(DATA_W'(1), DATA_W'(0));
    send_item(DATA_W'(1), DATA_W'(TOP_30));
    send_item(DATA_W'(PRIME - 1), DATA_W'(0));
    send_item(DATA_W'(PRIME - 1), DATA_W'(1));
    send_item(DATA_W'(PRIME - 1), DATA_W'(2));
    send_item(DATA_W'(PRIME - 1), DATA_W'(TOP_30));
    send_item(DATA_W'(PRIME - 1), DATA_W'(TOP_30 - 1));
    send_item(DATA_W'(PRIME), DATA_W'(5));
    send_item(DATA_W'(PRIME), DATA_W'(0));
    send_item(DATA_W'(PRIME + 1), DATA_W'(12345));
    send_item(DATA_W'(TOP_30), DATA_W'(0));
    send_item(DATA_W'(TOP_30), DATA_W'(1));
    send_item(DATA_W'(TOP_30), DATA_W'(TOP_30));
    send_item(DATA_W'(2), DATA_W'(29));
    send_item(DATA_W'(2), DATA_W'(TOP_30));
    send_item(DATA_W'(5), DATA_W'(1) << 29);
    send_item(DATA_W'(123456789), DATA_W'(PRIME - 1));
    send_item(DATA_W'(123456789), DATA_W'(PRIME - 2));
    n_directed = sent;

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 100) hold_off_go = 1'b1;
      if (i == 250) begin
        // drain the block completely before going on
        item_if.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      calm = (i >= 300 && i < 360);

      case ($urandom_range(0, 9))
        0:       b = DATA_W'($urandom_range(0, 2));
        1:       b = DATA_W'(PRIME - 1 - $urandom_range(0, 2));
        2:       b = DATA_W'($urandom_range(PRIME, TOP_30));
        3:       b = DATA_W'($urandom());
        default: b = DATA_W'($urandom_range(0, PRIME - 1));
      endcase
      case ($urandom_range(0, 9))
        0, 1:    e = DATA_W'($urandom_range(0, 64));
        2:       e = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
        3:       e = ~(DATA_W'(1) << $urandom_range(0, DATA_W - 1));
        4:       e = DATA_W'($urandom() >> $urandom_range(0, 31));
        default: e = DATA_W'($urandom());
      endcase
      send_item(b, e);
    end

    item_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d directed and %0d random base/exponent pairs, checked %0d powers;",
             n_directed, sent - n_directed, result_count);
    $display("run included a %0d-cycle output hold-off, a full drain and a stall-free stretch.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
